// ===== rtl/itp_pkg.sv =====
// Shared types, character codes and helper functions of the infix to postfix converter.
package itp_pkg;

    // Operator stack entry code.
    typedef logic [2:0] t_code;

    localparam t_code CODE_NONE   = 3'd0;
    localparam t_code CODE_LPAREN = 3'd1;
    localparam t_code CODE_PLUS   = 3'd2;
    localparam t_code CODE_MINUS  = 3'd3;
    localparam t_code CODE_MUL    = 3'd4;
    localparam t_code CODE_DIV    = 3'd5;

    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_MUL    = 8'h2A;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_DIV    = 8'h2F;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam logic [1:0] PREC_LOW  = 2'd1;
    localparam logic [1:0] PREC_HIGH = 2'd2;

    // Payload of one input item.
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    // Payload of one result item.
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_empty;
        logic       out_last;
        logic       out_error;
    } t_out_item;

    // Map a character to its stack code; anything else gives CODE_NONE.
    function automatic t_code code_of(input logic [7:0] c);
        t_code code;
        case (c)
            CHAR_LPAREN: code = CODE_LPAREN;
            CHAR_PLUS:   code = CODE_PLUS;
            CHAR_MINUS:  code = CODE_MINUS;
            CHAR_MUL:    code = CODE_MUL;
            CHAR_DIV:    code = CODE_DIV;
            default:     code = CODE_NONE;
        endcase
        return code;
    endfunction

    // Map a stack code back to its character.
    function automatic logic [7:0] char_of(input t_code code);
        logic [7:0] c;
        case (code)
            CODE_LPAREN: c = CHAR_LPAREN;
            CODE_PLUS:   c = CHAR_PLUS;
            CODE_MINUS:  c = CHAR_MINUS;
            CODE_MUL:    c = CHAR_MUL;
            CODE_DIV:    c = CHAR_DIV;
            default:     c = CHAR_NUL;
        endcase
        return c;
    endfunction

    // Precedence: multiply and divide bind tighter than add and subtract.
    function automatic logic [1:0] prec_of(input t_code code);
        logic [1:0] p;
        case (code)
            CODE_PLUS, CODE_MINUS: p = PREC_LOW;
            CODE_MUL, CODE_DIV:    p = PREC_HIGH;
            default:               p = 2'd0;
        endcase
        return p;
    endfunction

    // True for ASCII letters and digits.
    function automatic logic is_alnum(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

endpackage

// ===== rtl/itp_stream_if.sv =====
// Valid/ready stream channel carrying one item of type T.
interface itp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/itp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix to postfix converter.
//
//   Channel  Dir  Payload                                     Handshake
//   i_in     in   in_char[7:0], in_last                       valid/ready
//   o_out    out  out_char[7:0], out_empty, out_last,         valid/ready
//                 out_error
//
// A character is accepted in S_IDLE and then acted on by the sequencer in
// S_MAIN, which pops one operator per step before it is done; the stack RAM
// delivers one new top entry per cycle. A character flagged last moves on
// to S_FLUSH, which pops each remaining stack entry and then closes the
// expression. A stalled output holds the sequencer; no input item is
// taken until the current one is done. Reset is synchronous and needs no
// clearing pass over the stack RAM.
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itp_stream_if.sink  i_in,
    itp_stream_if.source o_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MAIN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [7:0]    r_char;
    logic          r_last;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;

    logic          r_fwd_valid;
    t_code         r_fwd_code;

    logic          r_hold_valid, n_hold_valid;
    logic [7:0]    r_hold_char, n_hold_char;
    logic          r_hold_err, n_hold_err;

    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    // Sequencer decisions.
    logic          w_emit;
    logic [7:0]    w_emit_char;
    logic          w_pop;
    logic          w_push;
    t_code         w_push_code;
    logic          w_end;

    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [CW-1:0] w_rcount;
    logic [2:0]    w_rdata;
    t_code         w_top;
    t_code         w_code;
    logic          w_alnum;
    logic          w_full;
    logic          w_nonempty;
    logic          w_out_free;
    logic          w_emit_ok;
    t_state        w_after;

    // Operator stack storage.
    itp_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_push_code),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The read address always follows the next top, so the top entry is ready
    // every cycle. A push in the previous cycle is forwarded around the RAM.
    assign w_rcount = n_count - CW'(1);
    assign w_raddr  = (n_count == '0) ? '0 : w_rcount[AW-1:0];
    assign w_top    = r_fwd_valid ? r_fwd_code : t_code'(w_rdata);

    assign w_code     = code_of(r_char);
    assign w_alnum    = is_alnum(r_char);
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_nonempty = (r_count != '0);
    assign w_out_free = !r_out_valid || o_out.ready;
    // Results of a final item pass through the hold stage so the last one can be marked.
    assign w_emit_ok  = r_last ? (!r_hold_valid || w_out_free) : w_out_free;
    assign w_after    = r_last ? S_FLUSH : S_IDLE;
    assign w_we       = w_push && !w_full;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Sequencer: at most one stack action per cycle; a stalled output holds it.
    always_comb begin
        n_state     = r_state;
        w_emit      = 1'b0;
        w_emit_char = CHAR_NUL;
        w_pop       = 1'b0;
        w_push      = 1'b0;
        w_push_code = CODE_NONE;
        w_end       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_MAIN;
                end
            end
            S_MAIN: begin
                if (w_alnum) begin
                    if (w_emit_ok) begin
                        w_emit      = 1'b1;
                        w_emit_char = r_char;
                        n_state     = w_after;
                    end
                end else if (w_code == CODE_LPAREN) begin
                    w_push      = 1'b1;
                    w_push_code = CODE_LPAREN;
                    n_state     = w_after;
                end else if (r_char == CHAR_RPAREN) begin
                    if (w_nonempty && w_top != CODE_LPAREN) begin
                        if (w_emit_ok) begin
                            w_emit      = 1'b1;
                            w_pop       = 1'b1;
                            w_emit_char = char_of(w_top);
                        end
                    end else begin
                        // Drop the matching opening parenthesis, if any.
                        w_pop   = w_nonempty;
                        n_state = w_after;
                    end
                end else if (w_code != CODE_NONE) begin
                    if (w_nonempty && prec_of(w_code) <= prec_of(w_top)) begin
                        if (w_emit_ok) begin
                            w_emit      = 1'b1;
                            w_pop       = 1'b1;
                            w_emit_char = char_of(w_top);
                        end
                    end else begin
                        w_push      = 1'b1;
                        w_push_code = w_code;
                        n_state     = w_after;
                    end
                end else begin
                    n_state = w_after;
                end
            end
            S_FLUSH: begin
                if (w_nonempty) begin
                    if (w_emit_ok) begin
                        w_emit      = 1'b1;
                        w_pop       = 1'b1;
                        w_emit_char = char_of(w_top);
                    end
                end else if (w_out_free) begin
                    w_end   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Stack count and overflow flag.
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_pop) begin
            n_count = r_count - CW'(1);
        end
        if (w_push) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        if (w_end) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    // Hold stage and output register.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_hold_valid = r_hold_valid;
        n_hold_char  = r_hold_char;
        n_hold_err   = r_hold_err;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_emit) begin
            if (!r_last) begin
                n_out_valid = 1'b1;
                n_out       = '{out_char: w_emit_char, out_empty: 1'b0,
                                out_last: 1'b0, out_error: r_ovf};
            end else begin
                if (r_hold_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_char: r_hold_char, out_empty: 1'b0,
                                    out_last: 1'b0, out_error: r_hold_err};
                end
                n_hold_valid = 1'b1;
                n_hold_char  = w_emit_char;
                n_hold_err   = r_ovf;
            end
        end
        if (w_end) begin
            n_out_valid = 1'b1;
            if (r_hold_valid) begin
                n_out        = '{out_char: r_hold_char, out_empty: 1'b0,
                                 out_last: 1'b1, out_error: r_hold_err};
                n_hold_valid = 1'b0;
            end else begin
                // Nothing came from this expression: send the end marker alone.
                n_out = '{out_char: CHAR_NUL, out_empty: 1'b1,
                          out_last: 1'b1, out_error: r_ovf};
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_fwd_valid  <= w_we;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && r_state == S_IDLE) begin
            r_char <= i_in.data.in_char;
            r_last <= i_in.data.in_last;
        end
        r_fwd_code  <= w_push_code;
        r_hold_char <= n_hold_char;
        r_hold_err  <= n_hold_err;
        r_out       <= n_out;
    end

endmodule
